>>> hw/rtl/gccc_pkg.sv
// ----------------------------------------------------------------------------
// gccc_pkg
// Shared types and constants for the graph cycle and connectivity checker.
// ----------------------------------------------------------------------------
package gccc_pkg;

  localparam int unsigned MaxNodes = 32;
  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned CountW   = 6;
  localparam int unsigned AddrW    = 1;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_EVAL = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CYC_ROOT,
    ST_CYC_READ,
    ST_CYC_STEP,
    ST_CON_READ,
    ST_CON_STEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] src_node;
    logic [4:0] dst_node;
  } in_item_t;

  typedef struct packed {
    logic acyclic;
    logic connected;
  } out_item_t;

  localparam logic [AddrW-1:0] RegNodeCount = 1'b0;

endpackage

>>> hw/rtl/gccc_ram.sv
// ----------------------------------------------------------------------------
// gccc_ram
// Generic single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module gccc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/graph_cycle_and_connectivity_check_top.sv
// ----------------------------------------------------------------------------
// graph_cycle_and_connectivity_check_top
// Directed graph held as an adjacency bit matrix in RAM; evaluates acyclicity
// and weak connectivity from node 0 by depth-first search.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/ready_o  | in_item_t (operation, src, dst)
//  out     | output    | out_valid_o/ready_i | out_item_t (acyclic, connected)
//  cfg     | input     | APB psel/penable    | node_count
//
// An edge update reads the source row and the transposed destination row in
// the accepting cycle and writes both back in the next cycle. An evaluation
// first runs the cycle search from each unvisited root in turn, stopping at the
// first edge back onto the search path, and then the connectivity walk and the
// result. After reset a clearing pass zeroes both RAMs; no item is taken
// meanwhile. A waiting result does not block the next edge update; the next
// evaluation waits until the result is taken.
module graph_cycle_and_connectivity_check_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gccc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gccc_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [gccc_pkg::AddrW+1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned N  = gccc_pkg::MaxNodes;
  localparam int unsigned NW = gccc_pkg::NodeW;

  gccc_pkg::state_e state_q, state_d;
  logic [gccc_pkg::CountW-1:0] node_count_q;
  logic [NW:0]   n_eff;
  logic [N-1:0]  live_mask;

  logic [N-1:0]  visited_q, visited_d, on_path_q, on_path_d;
  logic [NW-1:0] stack_q [N];
  logic [NW:0]   depth_q, depth_d;
  logic [NW:0]   root_q, root_d;
  logic [NW:0]   clr_q, clr_d;
  logic          cyc_q, cyc_d;
  logic          busy_op_q, busy_op_d;
  logic [NW-1:0] node_q, node_d;
  gccc_pkg::in_item_t item_q;
  logic          out_valid_q, out_valid_d;
  gccc_pkg::out_item_t out_q, out_d;

  // stack write port
  logic          push;
  logic [NW-1:0] push_addr;
  logic [NW-1:0] push_node;

  // Row RAM holds out-edges, the transposed RAM holds in-edges of each node.
  logic          we;
  logic [NW-1:0] waddr, raddr, waddr_t, raddr_t;
  logic [N-1:0]  wdata, rdata, wdata_t, rdata_t;

  gccc_ram #(.Width(N), .Depth(N)) u_adj (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  gccc_ram #(.Width(N), .Depth(N)) u_adj_t (
    .clk_i, .we_i(we), .waddr_i(waddr_t), .wdata_i(wdata_t),
    .raddr_i(raddr_t), .rdata_o(rdata_t)
  );

  always_comb begin
    if (node_count_q == '0) begin
      n_eff = (NW+1)'(1);
    end else if (node_count_q > (gccc_pkg::CountW)'(N)) begin
      n_eff = (NW+1)'(N);
    end else begin
      n_eff = (NW+1)'(node_count_q);
    end
    for (int i = 0; i < N; i++) begin
      live_mask[i] = (i < int'(n_eff));
    end
  end

  assign pready = 1'b1;
  assign prdata = {{(32-gccc_pkg::CountW){1'b0}}, node_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= (gccc_pkg::CountW)'(N);
    end else if (psel && penable && pwrite &&
                 paddr[gccc_pkg::AddrW+1:2] == gccc_pkg::RegNodeCount) begin
      node_count_q <= pwdata[gccc_pkg::CountW-1:0];
    end
  end

  logic in_fire, edge_ok;
  logic [N-1:0] nb, cand, first_cand;
  logic [NW-1:0] first_idx;
  logic          has_cand, hit_path;
  logic [NW-1:0] top;

  assign in_fire = in_valid_i && in_ready_o;
  assign edge_ok = ({1'b0, in_item_i.src_node} < n_eff) &&
                   ({1'b0, in_item_i.dst_node} < n_eff);
  assign top     = stack_q[depth_q[NW-1:0] - NW'(1)];

  always_comb begin
    if (state_q == gccc_pkg::ST_CON_STEP) begin
      nb = (rdata | rdata_t) & live_mask;
    end else begin
      nb = rdata & live_mask;
    end
    hit_path = |(nb & on_path_q);
    cand     = nb & ~visited_q;
    has_cand = |cand;
    first_cand = cand & (~cand + N'(1));
    first_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (first_cand[i]) first_idx = NW'(i);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gccc_pkg::ST_CLEAR:    if (clr_q == (NW+1)'(N-1)) state_d = gccc_pkg::ST_IDLE;
      gccc_pkg::ST_IDLE: begin
        if (busy_op_q) state_d = gccc_pkg::ST_IDLE;
        else if (in_fire && in_item_i.operation == gccc_pkg::OP_EVAL) begin
          state_d = gccc_pkg::ST_CYC_ROOT;
        end
      end
      gccc_pkg::ST_CYC_ROOT: begin
        if (root_q >= n_eff) state_d = gccc_pkg::ST_CON_READ;
        else if (!visited_q[root_q[NW-1:0]]) state_d = gccc_pkg::ST_CYC_READ;
      end
      gccc_pkg::ST_CYC_READ: state_d = gccc_pkg::ST_CYC_STEP;
      gccc_pkg::ST_CYC_STEP: begin
        if (hit_path) state_d = gccc_pkg::ST_CON_READ;
        else if (has_cand) state_d = gccc_pkg::ST_CYC_READ;
        else if (depth_q == (NW+1)'(1)) state_d = gccc_pkg::ST_CYC_ROOT;
        else state_d = gccc_pkg::ST_CYC_READ;
      end
      gccc_pkg::ST_CON_READ: begin
        if (depth_q == '0) state_d = gccc_pkg::ST_DONE;
        else state_d = gccc_pkg::ST_CON_STEP;
      end
      gccc_pkg::ST_CON_STEP: state_d = gccc_pkg::ST_CON_READ;
      gccc_pkg::ST_DONE:     if (!out_valid_q) state_d = gccc_pkg::ST_IDLE;
      default:               state_d = gccc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    visited_d   = visited_q;
    on_path_d   = on_path_q;
    depth_d     = depth_q;
    root_d      = root_q;
    clr_d       = clr_q;
    cyc_d       = cyc_q;
    busy_op_d   = 1'b0;
    node_d      = node_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    push        = 1'b0;
    push_addr   = depth_q[NW-1:0];
    push_node   = '0;
    we          = 1'b0;
    waddr       = item_q.src_node;
    wdata       = rdata;
    raddr       = in_item_i.src_node;
    waddr_t     = item_q.dst_node;
    wdata_t     = rdata_t;
    raddr_t     = in_item_i.dst_node;
    in_ready_o  = 1'b0;
    case (state_q)
      gccc_pkg::ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_q[NW-1:0];
        waddr_t = clr_q[NW-1:0];
        wdata   = '0;
        wdata_t = '0;
        clr_d   = clr_q + (NW+1)'(1);
      end
      gccc_pkg::ST_IDLE: begin
        if (busy_op_q) begin
          // Write back both rows read last cycle.
          we = 1'b1;
          wdata[item_q.dst_node]   = (item_q.operation == gccc_pkg::OP_ADD);
          wdata_t[item_q.src_node] = (item_q.operation == gccc_pkg::OP_ADD);
        end else begin
          in_ready_o = !out_valid_q ||
                       in_item_i.operation != gccc_pkg::OP_EVAL;
          if (in_fire) begin
            if ((in_item_i.operation == gccc_pkg::OP_ADD ||
                 in_item_i.operation == gccc_pkg::OP_DEL) && edge_ok) begin
              busy_op_d = 1'b1;
            end
            visited_d = '0;
            on_path_d = '0;
            depth_d   = '0;
            root_d    = '0;
            cyc_d     = 1'b1;
          end
        end
      end
      gccc_pkg::ST_CYC_ROOT: begin
        if (root_q >= n_eff) begin
          // All roots are done; the connectivity walk starts from node 0.
          visited_d = N'(1);
          on_path_d = '0;
          push      = 1'b1;
          push_addr = '0;
          push_node = '0;
          depth_d   = (NW+1)'(1);
        end else if (!visited_q[root_q[NW-1:0]]) begin
          visited_d[root_q[NW-1:0]] = 1'b1;
          on_path_d[root_q[NW-1:0]] = 1'b1;
          push      = 1'b1;
          push_node = root_q[NW-1:0];
          depth_d   = depth_q + (NW+1)'(1);
        end
        root_d = root_q + (NW+1)'(1);
      end
      gccc_pkg::ST_CYC_READ: begin
        raddr   = top;
        raddr_t = top;
        node_d  = top;
      end
      gccc_pkg::ST_CYC_STEP: begin
        if (hit_path) begin
          cyc_d     = 1'b0;
          visited_d = N'(1);
          on_path_d = '0;
          push      = 1'b1;
          push_addr = '0;
          push_node = '0;
          depth_d   = (NW+1)'(1);
        end else if (has_cand) begin
          visited_d = visited_q | first_cand;
          on_path_d = on_path_q | first_cand;
          push      = 1'b1;
          push_node = first_idx;
          depth_d   = depth_q + (NW+1)'(1);
        end else begin
          on_path_d[node_q] = 1'b0;
          depth_d = depth_q - (NW+1)'(1);
        end
      end
      gccc_pkg::ST_CON_READ: begin
        if (depth_q != '0) begin
          raddr   = top;
          raddr_t = top;
          node_d  = top;
        end
      end
      gccc_pkg::ST_CON_STEP: begin
        // Neighbors in either direction; one new node is pushed per step.
        if (has_cand) begin
          visited_d = visited_q | first_cand;
          push      = 1'b1;
          push_node = first_idx;
          depth_d   = depth_q + (NW+1)'(1);
        end else begin
          depth_d = depth_q - (NW+1)'(1);
        end
      end
      gccc_pkg::ST_DONE: begin
        if (!out_valid_q) begin
          out_valid_d     = 1'b1;
          out_d.acyclic   = cyc_q;
          out_d.connected = ((visited_q & live_mask) == live_mask);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[push_addr] <= push_node;
    end
    if (in_fire) begin
      item_q <= in_item_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gccc_pkg::ST_CLEAR;
      visited_q   <= '0;
      on_path_q   <= '0;
      depth_q     <= '0;
      root_q      <= '0;
      clr_q       <= '0;
      cyc_q       <= 1'b1;
      busy_op_q   <= 1'b0;
      node_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      visited_q   <= visited_d;
      on_path_q   <= on_path_d;
      depth_q     <= depth_d;
      root_q      <= root_d;
      clr_q       <= clr_d;
      cyc_q       <= cyc_d;
      busy_op_q   <= busy_op_d;
      node_q      <= node_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= (NW+1)'(N))
    else $error("stack depth overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gccc_pkg::ST_CLEAR |-> !in_ready_o)
    else $error("item accepted during clearing pass");

endmodule
